FILE: src/mep_pkg.sv
// shared types, constants and helpers for the escape-time pixel engine
// no dependencies; imported by every module of the block
package mep_pkg;

  // coordinate, multiplier operand, configuration and gray level widths
  localparam int COORD_W    = 32;
  localparam int MUL_W      = COORD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GRAY_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

  // saturation bounds of a coordinate
  localparam logic signed [63:0] COORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] COORD_MIN = -64'sd2147483648;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_ABS,
    S_MAP_DIV,
    S_MAP_WAIT,
    S_MAP_ADD,
    S_IT_RR,
    S_IT_II,
    S_IT_CHK,
    S_IT_UPD,
    S_GRAY_DIV,
    S_GRAY_WAIT
  } state_t;

  // clamp a wide signed value into the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/mep_mul.sv
// shared signed multiplier with a registered product
// depends on mep_pkg for the operand width
module mep_mul (
  input  logic                                clk,
  input  logic signed [mep_pkg::MUL_W-1:0]    a,
  input  logic signed [mep_pkg::MUL_W-1:0]    b,
  output logic signed [2*mep_pkg::MUL_W-1:0]  p
);
  import mep_pkg::*;

  // one product per cycle, registered: the product appears in the cycle after its operands
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: src/mep_div.sv
// iterative restoring divider, unsigned, one quotient bit per cycle
// depends on mep_pkg; used for the coordinate mapping and the gray level
module mep_div #(
  parameter int DVD_W = 44,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot
);
  import mep_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_sub;
  logic [DVS_W-1:0] rem_next;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh   = {rem, quot[DVD_W-1]};
    rem_sub  = rem_sh - {1'b0, dvs};
    ge       = (rem_sh >= {1'b0, dvs});
    rem_next = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  // step counter and completion strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      quot <= dividend;
    end else if (running) begin
      rem  <= rem_next;
      quot <= {quot[DVD_W-2:0], ge};
    end
  end

endmodule

FILE: src/mandelbrot_escape_pixel.sv
// escape-time pixel engine: maps the pixel to c with two divides, iterates, then divides
// for the gray level; the gray divide is skipped when max_iter is 0.
// one pixel at a time, busy meanwhile; the next request is taken in the done cycle.
// each iteration steps through S_IT_RR, S_IT_II, S_IT_CHK and S_IT_UPD and takes three
// products on one shared 33x33 multiplier; the two mapping divides and the gray divide share one divider.
// done strobes for one cycle and cannot be held off; sync reset restores the default window.
module mandelbrot_escape_pixel #(
  parameter int DIM_BITS  = 12,
  parameter int ITER_BITS = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [DIM_BITS-1:0]               pixel_col,
  input  logic [DIM_BITS-1:0]               pixel_row,
  input  logic                              wr_en,
  input  logic [mep_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]    wr_data,
  output logic                              done,
  output logic [DIM_BITS-1:0]               out_col,
  output logic [DIM_BITS-1:0]               out_row,
  output logic [ITER_BITS-1:0]              iter_count,
  output logic [mep_pkg::GRAY_W-1:0]        gray_level
);
  import mep_pkg::*;

  localparam int DVD_W  = DIM_BITS + 32;
  localparam int DVS_W  = (DIM_BITS + 1 > ITER_BITS) ? DIM_BITS + 1 : ITER_BITS;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic signed [COORD_W-1:0] X_MIN_RST = -(32'sd1 <<< (FRAC_BITS + 1));
  localparam logic signed [COORD_W-1:0] X_MAX_RST = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [COORD_W-1:0] Y_MIN_RST = -(32'sd3 <<< (FRAC_BITS - 1));
  localparam logic signed [COORD_W-1:0] Y_MAX_RST = 32'sd3 <<< (FRAC_BITS - 1);
  localparam logic [DIM_BITS:0]         DIM_RST   = (DIM_BITS + 1)'(512);
  localparam logic [ITER_BITS-1:0]      ITER_RST  = ITER_BITS'(1000);
  localparam logic [63:0]               ESC_LIMIT = 64'd1 << (2 * FRAC_BITS + 4);

  // configuration registers
  logic signed [COORD_W-1:0] x_min, x_max, y_min, y_max;
  logic [DIM_BITS:0]         image_width, image_height;
  logic [ITER_BITS-1:0]      max_iter;

  // sequencer
  state_t state, state_next;

  // working registers
  logic [DIM_BITS-1:0]       col, row;
  logic signed [MUL_W-1:0]   span_x, span_y;
  logic                      axis;
  logic                      neg;
  logic [DVD_W-1:0]          mag;
  logic signed [DVD_W:0]     q_s;
  logic signed [COORD_W-1:0] cre, cim, re, im;
  logic [63:0]               rr;
  logic signed [63:0]        rr_minus_ii;
  logic [ITER_BITS-1:0]      iter;

  // shared units
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  p;
  logic                      div_start, div_done;
  logic [DVD_W-1:0]          div_dividend, div_quot;
  logic [DVS_W-1:0]          div_divisor;

  // datapath helpers
  logic [DIM_BITS:0]         width_eff, height_eff;
  logic signed [PROD_W-1:0]  p_abs;
  logic [63:0]               p_u;
  logic signed [63:0]        p_s;
  logic [ITER_BITS+7:0]      gray_dvd;
  logic signed [COORD_W-1:0] map_lo;
  logic signed [63:0]        map_sum, re_sum, im_sum;
  logic                      stop;
  logic                      finish;

  mep_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  mep_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min        <= X_MIN_RST;
      x_max        <= X_MAX_RST;
      y_min        <= Y_MIN_RST;
      y_max        <= Y_MAX_RST;
      image_width  <= DIM_RST;
      image_height <= DIM_RST;
      max_iter     <= ITER_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_X_MIN:    x_min        <= wr_data;
        REG_X_MAX:    x_max        <= wr_data;
        REG_Y_MIN:    y_min        <= wr_data;
        REG_Y_MAX:    y_max        <= wr_data;
        REG_WIDTH:    image_width  <= wr_data[DIM_BITS:0];
        REG_HEIGHT:   image_height <= wr_data[DIM_BITS:0];
        REG_MAX_ITER: max_iter     <= wr_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // shared datapath arithmetic
  always_comb begin
    width_eff  = (image_width == '0) ? (DIM_BITS + 1)'(1) : image_width;
    height_eff = (image_height == '0) ? (DIM_BITS + 1)'(1) : image_height;
    p_abs      = p[PROD_W-1] ? -p : p;
    p_u        = p[63:0];
    p_s        = p[63:0];
    gray_dvd   = {iter, 8'h00} - {8'h00, iter};
    map_lo     = axis ? y_min : x_min;
    map_sum    = 64'(map_lo) + 64'(q_s);
    re_sum     = (rr_minus_ii >>> FRAC_BITS) + 64'(cre);
    im_sum     = ((p_s >>> FRAC_BITS) <<< 1) + 64'(cim);
    stop       = ((rr + p_u) >= ESC_LIMIT) || (iter >= max_iter);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (start) state_next = S_MAP_MUL;
      S_MAP_MUL:   state_next = S_MAP_ABS;
      S_MAP_ABS:   state_next = S_MAP_DIV;
      S_MAP_DIV:   state_next = S_MAP_WAIT;
      S_MAP_WAIT:  if (div_done) state_next = S_MAP_ADD;
      S_MAP_ADD:   state_next = axis ? S_IT_RR : S_MAP_MUL;
      S_IT_RR:     state_next = S_IT_II;
      S_IT_II:     state_next = S_IT_CHK;
      S_IT_CHK: begin
        if (!stop) begin
          state_next = S_IT_UPD;
        end else if (max_iter == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_GRAY_DIV;
        end
      end
      S_IT_UPD:    state_next = S_IT_RR;
      S_GRAY_DIV:  state_next = S_GRAY_WAIT;
      S_GRAY_WAIT: if (div_done) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // unit operands and strobes
  always_comb begin
    div_start    = 1'b0;
    div_dividend = mag;
    div_divisor  = DVS_W'(axis ? height_eff : width_eff);
    mul_a        = MUL_W'(re);
    mul_b        = MUL_W'(im);
    finish       = 1'b0;
    unique case (state)
      S_MAP_MUL: begin
        mul_a = axis ? $signed({{(MUL_W - DIM_BITS){1'b0}}, row})
                     : $signed({{(MUL_W - DIM_BITS){1'b0}}, col});
        mul_b = axis ? span_y : span_x;
      end
      S_MAP_DIV: div_start = 1'b1;
      S_IT_RR: begin
        mul_a = MUL_W'(re);
        mul_b = MUL_W'(re);
      end
      S_IT_II: begin
        mul_a = MUL_W'(im);
        mul_b = MUL_W'(im);
      end
      S_IT_CHK: finish = stop && (max_iter == '0);
      S_GRAY_DIV: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(gray_dvd);
        div_divisor  = DVS_W'(max_iter);
      end
      S_GRAY_WAIT: finish = div_done;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          col    <= pixel_col;
          row    <= pixel_row;
          span_x <= MUL_W'(x_max) - MUL_W'(x_min);
          span_y <= MUL_W'(y_max) - MUL_W'(y_min);
          axis   <= 1'b0;
        end
      end
      S_MAP_ABS: begin
        neg <= p[PROD_W-1];
        mag <= p_abs[DVD_W-1:0];
      end
      S_MAP_WAIT: begin
        if (div_done) begin
          q_s <= neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        end
      end
      S_MAP_ADD: begin
        if (axis) begin
          cim <= sat_coord(map_sum);
        end else begin
          cre <= sat_coord(map_sum);
        end
        axis <= 1'b1;
        re   <= '0;
        im   <= '0;
        iter <= '0;
      end
      S_IT_II:  rr <= p_u;
      S_IT_CHK: rr_minus_ii <= $signed(rr) - p_s;
      S_IT_UPD: begin
        re   <= sat_coord(re_sum);
        im   <= sat_coord(im_sum);
        iter <= iter + 1'b1;
      end
      default: ;
    endcase
  end

  // result registers, held until the next result
  always_ff @(posedge clk) begin
    if (finish) begin
      out_col    <= col;
      out_row    <= row;
      iter_count <= iter;
      gray_level <= (max_iter == '0) ? '0 : div_quot[GRAY_W-1:0];
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: src/mep_check.sv
// port-level checker for the escape-time pixel engine, bound to the top level
// depends on mep_pkg and mandelbrot_escape_pixel
module mep_check #(
  parameter int ITER_BITS = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [ITER_BITS-1:0]        iter_count,
  input logic [mep_pkg::GRAY_W-1:0]  gray_level
);
  import mep_pkg::*;

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // a result only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without prior work");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // no iterations means a black pixel
  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (iter_count == '0)) |-> (gray_level == '0))
    else $error("gray level nonzero with zero iterations");

endmodule

bind mandelbrot_escape_pixel mep_check #(.ITER_BITS(ITER_BITS)) u_mep_check (.*);

FILE: tb/mandelbrot_escape_pixel_checker.sv
`timescale 1ns / 1ps
// escape-time pixel checker: watches the register writes, the pixel requests and the done strobes
// keeps its own copy of the view window and predicts each pixel result; depends on mep_pkg
module mandelbrot_escape_pixel_checker #(
  parameter int DIM_BITS  = 12,
  parameter int ITER_BITS = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [DIM_BITS-1:0]            pixel_col,
  input  logic [DIM_BITS-1:0]            pixel_row,
  input  logic                           wr_en,
  input  logic [mep_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic                           done,
  input  logic [DIM_BITS-1:0]            out_col,
  input  logic [DIM_BITS-1:0]            out_row,
  input  logic [ITER_BITS-1:0]           iter_count,
  input  logic [mep_pkg::GRAY_W-1:0]     gray_level,
  output int                             fail_count,
  output int                             pending
);
  import mep_pkg::*;

  // squared magnitude at which a point has escaped: 16 in the product scale
  localparam logic [63:0] ESC_LIMIT = 64'd16 << (2 * FRAC_BITS);

  typedef struct packed {
    logic [DIM_BITS-1:0]  col;
    logic [DIM_BITS-1:0]  row;
    logic [ITER_BITS-1:0] iters;
    logic [GRAY_W-1:0]    gray;
  } pixel_result_t;

  // view window and limits as the block holds them
  logic signed [31:0]   view_x_min, view_x_max, view_y_min, view_y_max;
  logic [DIM_BITS:0]    img_width, img_height;
  logic [ITER_BITS-1:0] iter_limit;

  pixel_result_t pixel_q[$];
  pixel_result_t want;
  int            errs = 0;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // pixel index to coordinate, division truncating toward zero
  function automatic logic signed [31:0] axis_point(input logic signed [31:0] lo,
                                                    input logic signed [31:0] hi,
                                                    input logic [DIM_BITS-1:0] idx,
                                                    input logic [DIM_BITS:0] n);
    logic signed [63:0] lo_w, hi_w, span, pos, cnt;
    lo_w = 64'(lo);
    hi_w = 64'(hi);
    span = hi_w - lo_w;
    pos  = {{(64-DIM_BITS){1'b0}}, idx};
    // zero size counts as one
    if (n == 0) cnt = 64'sd1;
    else cnt = {{(63-DIM_BITS){1'b0}}, n};
    return clamp32(lo_w + (pos * span) / cnt);
  endfunction

  // escape count and gray level of one pixel
  function automatic pixel_result_t escape_pixel(input logic [DIM_BITS-1:0] col,
                                                 input logic [DIM_BITS-1:0] row);
    logic signed [63:0] cre, cim, re, im, rr, ii, ri, dif;
    logic [63:0]        mag;
    int unsigned        iters, gray;
    bit                 stop;
    pixel_result_t      res;
    cre   = 64'(axis_point(view_x_min, view_x_max, col, img_width));
    cim   = 64'(axis_point(view_y_min, view_y_max, row, img_height));
    re    = 0;
    im    = 0;
    iters = 0;
    stop  = 0;
    while (!stop) begin
      rr  = re * re;
      ii  = im * im;
      mag = rr + ii;
      if (mag >= ESC_LIMIT || iters >= iter_limit) begin
        stop = 1;
      end else begin
        ri  = re * im;
        dif = rr - ii;
        re  = 64'(clamp32((dif >>> FRAC_BITS) + cre));
        im  = 64'(clamp32(2 * (ri >>> FRAC_BITS) + cim));
        iters++;
      end
    end
    gray = (iter_limit == 0) ? 0 : (255 * iters) / iter_limit;
    res.col   = col;
    res.row   = row;
    res.iters = iters[ITER_BITS-1:0];
    res.gray  = gray[GRAY_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      view_x_min = -32'sd2 <<< FRAC_BITS;
      view_x_max = 32'sd1 <<< FRAC_BITS;
      view_y_min = -32'sd3 <<< (FRAC_BITS - 1);
      view_y_max = 32'sd3 <<< (FRAC_BITS - 1);
      img_width  = 512;
      img_height = 512;
      iter_limit = 1000;
      pixel_q.delete();
    end else begin
      // result strobe: compare with the oldest request
      if (done) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual col %0d row %0d iter %0d",
                   $time, out_col, out_row, iter_count);
          errs++;
        end else begin
          want = pixel_q.pop_front();
          check_field("out_col", 32'(want.col), 32'(out_col));
          check_field("out_row", 32'(want.row), 32'(out_row));
          check_field("iter_count", 32'(want.iters), 32'(iter_count));
          check_field("gray_level", 32'(want.gray), 32'(gray_level));
        end
      end
      // register writes
      if (wr_en) begin
        case (wr_index)
          REG_X_MIN:    view_x_min = wr_data;
          REG_X_MAX:    view_x_max = wr_data;
          REG_Y_MIN:    view_y_min = wr_data;
          REG_Y_MAX:    view_y_max = wr_data;
          REG_WIDTH:    img_width  = wr_data[DIM_BITS:0];
          REG_HEIGHT:   img_height = wr_data[DIM_BITS:0];
          REG_MAX_ITER: iter_limit = wr_data[ITER_BITS-1:0];
          default: ;
        endcase
      end
      // accepted pixel request
      if (start && !busy) pixel_q.push_back(escape_pixel(pixel_col, pixel_row));
    end
    pending    <= pixel_q.size();
    fail_count <= errs;
  end

endmodule

FILE: tb/mandelbrot_escape_pixel_test.sv
`timescale 1ns / 1ps
// top of the escape-time pixel test: clock, reset, register setup and pixel requests
// depends on mep_pkg, mandelbrot_escape_pixel and mandelbrot_escape_pixel_checker
module mandelbrot_escape_pixel_test;
  import mep_pkg::*;

  localparam int DIM_BITS     = 12;
  localparam int ITER_BITS    = 16;
  localparam int FRAC_BITS    = 24;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int RANDOM_ITEMS = 585;
  localparam int CYCLE_LIMIT  = 8000000;
  localparam int TAIL_CYCLES  = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [DIM_BITS-1:0]   pixel_col = '0;
  logic [DIM_BITS-1:0]   pixel_row = '0;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  done;
  logic [DIM_BITS-1:0]   out_col, out_row;
  logic [ITER_BITS-1:0]  iter_count;
  logic [GRAY_W-1:0]     gray_level;
  int                    fail_count, pending;

  int burst_left = 0;
  int sent = 0;
  int cur_width = 512;

  mandelbrot_escape_pixel dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .out_col(out_col), .out_row(out_row),
    .iter_count(iter_count), .gray_level(gray_level)
  );

  mandelbrot_escape_pixel_checker #(
    .DIM_BITS(DIM_BITS), .ITER_BITS(ITER_BITS), .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .out_col(out_col), .out_row(out_row),
    .iter_count(iter_count), .gray_level(gray_level),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // overall run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[mandelbrot_escape_pixel] ERROR");
    $finish;
  end

  // one pixel request, with a random gap between bursts
  task automatic send_pixel(input logic [DIM_BITS-1:0] col, input logic [DIM_BITS-1:0] row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    start     <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // drop the request and wait until every result is back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // write the whole register set back to back
  task automatic load_view(input logic [31:0] x0, input logic [31:0] x1,
                           input logic [31:0] y0, input logic [31:0] y1,
                           input int w, input int h, input int iters);
    logic [CFG_DATA_W-1:0] vals[7];
    logic [CFG_IDX_W-1:0]  idxs[7];
    vals = '{x0, x1, y0, y1, w, h, iters};
    idxs = '{REG_X_MIN, REG_X_MAX, REG_Y_MIN, REG_Y_MAX, REG_WIDTH, REG_HEIGHT, REG_MAX_ITER};
    for (int i = 0; i < 7; i++) begin
      wr_en    <= 1'b1;
      wr_index <= idxs[i];
      wr_data  <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    @(posedge clk);
    cur_width = (w == 0) ? 1 : w;
  endtask

  // random window, mostly around the set, sometimes anywhere
  task automatic load_random_view();
    logic [31:0] x0, x1, y0, y1, t;
    int          w, h, iters;
    if ($urandom_range(0, 9) == 0) begin
      x0 = $urandom;
      x1 = $urandom;
      y0 = $urandom;
      y1 = $urandom;
    end else begin
      x0 = -(5 * ONE / 2) + int'($urandom_range(0, 2 * ONE));
      x1 = x0 + int'($urandom_range(0, 3 * ONE));
      y0 = -(3 * ONE / 2) + int'($urandom_range(0, 3 * ONE / 2));
      y1 = y0 + int'($urandom_range(0, 3 * ONE));
      if ($urandom_range(0, 7) == 0) begin
        t  = x0;
        x0 = x1;
        x1 = t;
      end
    end
    case ($urandom_range(0, 3))
      0: w = $urandom_range(1, 16);
      1: w = 4096;
      default: w = $urandom_range(1, 4096);
    endcase
    h = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4096);
    iters = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 400) : $urandom_range(1, 48);
    load_view(x0, x1, y0, y1, w, h, iters);
  endtask

  initial begin
    int phase_len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window: corner, interior point, c = -2, far outside, last pixel
    send_pixel(0, 0);
    send_pixel(256, 256);
    send_pixel(0, 256);
    send_pixel(4095, 4095);
    send_pixel(511, 511);
    wait_idle();

    // extreme edges, reversed imaginary span, zero width and height, single iteration
    load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    wait_idle();

    // zero iteration limit, one column, pixels outside the image
    load_view(-2 * ONE, ONE, -3 * ONE / 2, 3 * ONE / 2, 1, 4096, 0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2048, 100);
    wait_idle();

    // largest limit: c = 0 never escapes, the others escape fast
    load_view(0, 0, 0, 32'h7FFF_FFFF, 4096, 4096, 65535);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 64);
    wait_idle();

    // random windows, mostly columns inside the image
    while (sent < RANDOM_ITEMS + 15) begin
      load_random_view();
      phase_len = $urandom_range(20, 90);
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS + 15; i++) begin
        if ($urandom_range(0, 6) == 0) begin
          send_pixel(DIM_BITS'($urandom), DIM_BITS'($urandom));
        end else begin
          send_pixel(DIM_BITS'($urandom_range(0, cur_width - 1)), DIM_BITS'($urandom));
        end
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[mandelbrot_escape_pixel] OK");
    end else begin
      $display("[mandelbrot_escape_pixel] ERROR");
    end
    $finish;
  end

endmodule
